// ----- sv/fas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_pkg: shared constants and types for the truncating float32 adder
// Field positions of a single-precision word and the stage payload types.
// ----------------------------------------------------------------------------
package fas_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned ExpW   = 8;
	localparam int unsigned FracW  = 23;
	localparam int unsigned MantW  = 24;
	localparam int unsigned SumW   = 26;
	localparam int unsigned PosW   = 5;
	localparam int unsigned SignPos = 31;

	// aligned operands after the swap and shift stage
	typedef struct packed {
		logic               sign_lo;
		logic               sign_hi;
		logic [ExpW-1:0]    exp_hi;
		logic [MantW-1:0]   mant_lo;
		logic [MantW-1:0]   mant_hi;
	} fas_align_t;

	// signed magnitude after the add stage
	typedef struct packed {
		logic               sign;
		logic [ExpW-1:0]    exp_hi;
		logic [MantW:0]     mag;
	} fas_sum_t;

endpackage

// ----- sv/float32_add_sub_truncating.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_add_sub_truncating: single-precision add/subtract, truncating
// Three-stage pipeline: align, add, normalize. One pair per unstalled cycle.
// ----------------------------------------------------------------------------
// Accepts one operand pair every clock while in_stall is low and returns
// its sum through the align, add and normalize register stages. A result
// stall holds each full stage that cannot advance and stalls the input
// only when every stage is full. Results are truncated, the exponent wraps
// without a flag, and zero, denormal, infinity and NaN are not special.
module float32_add_sub_truncating import fas_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             func,
	input  logic [WordW-1:0] operand_a,
	input  logic [WordW-1:0] operand_b,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WordW-1:0] sum_word
);

	fas_align_t       align_c, align_s1;
	fas_sum_t         sum_c, sum_s2;
	logic [WordW-1:0] word_c, word_s3;
	logic             v_s1, v_s2, v_s3;
	logic             adv3, adv2, adv1;

	fas_align  u_align (.func, .operand_a, .operand_b, .aligned(align_c));
	fas_addmag u_add   (.aligned(align_s1), .summed(sum_c));
	fas_norm   u_norm  (.summed(sum_s2), .result(word_c));

	// advance a stage when its successor frees up
	assign adv3     = !v_s3 || !out_stall;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	// hold valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (adv1) align_s1 <= align_c;
		if (adv2) sum_s2   <= sum_c;
		if (adv3) word_s3  <= word_c;
	end

	assign out_valid = v_s3;
	assign sum_word  = word_s3;

endmodule

// ----- sv/fas_align.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_align: operand unpack, swap and alignment shift
// Picks the smaller-exponent operand and shifts its mantissa right.
// ----------------------------------------------------------------------------
module fas_align import fas_pkg::*; (
	input  logic             func,
	input  logic [WordW-1:0] operand_a,
	input  logic [WordW-1:0] operand_b,
	output fas_align_t       aligned
);

	logic [WordW-1:0] b_eff;
	logic [WordW-1:0] lo_w;
	logic [WordW-1:0] hi_w;
	logic [ExpW-1:0]  diff;
	logic [MantW-1:0] mlo;

	// flip the second sign for subtraction, order by exponent
	always_comb begin
		b_eff = operand_b ^ {func, {(WordW-1){1'b0}}};
		if (operand_a[30:23] > b_eff[30:23]) begin
			lo_w = b_eff;
			hi_w = operand_a;
		end else begin
			lo_w = operand_a;
			hi_w = b_eff;
		end
		diff = hi_w[30:23] - lo_w[30:23];
		mlo  = {1'b1, lo_w[FracW-1:0]};
		aligned.sign_lo = lo_w[SignPos];
		aligned.sign_hi = hi_w[SignPos];
		aligned.exp_hi  = hi_w[30:23];
		aligned.mant_hi = {1'b1, hi_w[FracW-1:0]};
		aligned.mant_lo = (diff >= ExpW'(MantW)) ? '0 : (mlo >> diff);
	end

endmodule

// ----- sv/fas_addmag.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_addmag: signed mantissa add and magnitude
// Sums the aligned mantissas in two's complement and splits sign from size.
// ----------------------------------------------------------------------------
module fas_addmag import fas_pkg::*; (
	input  fas_align_t aligned,
	output fas_sum_t   summed
);

	logic signed [SumW-1:0] slo;
	logic signed [SumW-1:0] shi;
	logic signed [SumW-1:0] sum;

	// negate by sign, add, take magnitude
	always_comb begin
		slo = aligned.sign_lo ? -$signed({2'b00, aligned.mant_lo})
		                      :  $signed({2'b00, aligned.mant_lo});
		shi = aligned.sign_hi ? -$signed({2'b00, aligned.mant_hi})
		                      :  $signed({2'b00, aligned.mant_hi});
		sum = slo + shi;
		summed.sign   = sum[SumW-1];
		summed.exp_hi = aligned.exp_hi;
		summed.mag    = sum[SumW-1] ? (MantW+1)'(-sum) : sum[MantW:0];
	end

endmodule

// ----- sv/fas_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_norm: leading-one detect and renormalize
// Moves the top one of the magnitude to bit 23 and adjusts the exponent.
// ----------------------------------------------------------------------------
module fas_norm import fas_pkg::*; (
	input  fas_sum_t         summed,
	output logic [WordW-1:0] result
);

	logic [PosW-1:0]  pos;
	logic             found;
	logic [MantW:0]   mag_n;
	logic [ExpW-1:0]  e;

	// find the highest set bit
	always_comb begin
		pos   = '0;
		found = 1'b0;
		for (int i = 0; i <= MantW; i++) begin
			if (summed.mag[i]) begin
				pos   = PosW'(i);
				found = 1'b1;
			end
		end
	end

	// shift into place and pack the word
	always_comb begin
		if (pos == PosW'(MantW)) begin
			mag_n = summed.mag >> 1;
			e     = summed.exp_hi + 8'd1;
		end else begin
			mag_n = summed.mag << (PosW'(FracW) - pos);
			e     = summed.exp_hi - ExpW'(PosW'(FracW) - pos);
		end
		result = found ? {summed.sign, e, mag_n[FracW-1:0]} : '0;
	end

endmodule
